[rtl/v3alu_pkg.sv]
// Shared types, constants and helpers of the three-component vector ALU.
`timescale 1ns / 1ps
package v3alu_pkg;

  localparam int DataW     = 32;
  localparam int ProdW     = 64;
  localparam int SumW      = 66;
  localparam int RadW      = 64;
  localparam int SqrtSteps = 32;
  localparam int Lanes     = 3;

  localparam logic signed [SumW-1:0] SumMax = 66'sd2147483647;
  localparam logic signed [SumW-1:0] SumMin = -66'sd2147483648;
  localparam logic [DataW-1:0] ValMax = 32'h7fff_ffff;
  localparam logic [DataW-1:0] ValMin = 32'h8000_0000;

  typedef enum logic [3:0] {
    KAdd   = 4'd0,
    KSub   = 4'd1,
    KMul   = 4'd2,
    KDiv   = 4'd3,
    KScale = 4'd4,
    KDivS  = 4'd5,
    KCross = 4'd6,
    KDot   = 4'd7,
    KSqLen = 4'd8,
    KLen   = 4'd9,
    KNorm  = 4'd10
  } kind_e;

  typedef struct packed {
    logic [3:0]        kind;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] scalar_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] scalar_out;
    logic               div_by_zero;
    logic               saturated;
  } out_item_t;

  // result computed ahead of the divider, carried down the pipe
  typedef struct packed {
    logic [3:0]        kind;
    logic [DataW-1:0]  rx;
    logic [DataW-1:0]  ry;
    logic [DataW-1:0]  rz;
    logic [DataW-1:0]  so;
    logic              sat;
  } early_t;

  // side payload that rides along the square root pipe
  typedef struct packed {
    early_t                       early;
    logic [Lanes-1:0][DataW-1:0]  num;
    logic [Lanes-1:0][DataW-1:0]  den;
  } sq_side_t;

  typedef struct packed {
    logic [DataW-1:0] val;
    logic             sat;
  } sat_t;

  // clip a wide signed value to the 32-bit range
  function automatic sat_t sat32(input logic signed [SumW-1:0] v);
    sat_t r;
    r.val = v[DataW-1:0];
    r.sat = 1'b0;
    if (v > SumMax) begin
      r.val = ValMax;
      r.sat = 1'b1;
    end else if (v < SumMin) begin
      r.val = ValMin;
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

[rtl/v3alu_if.sv]
// Valid/ready channel interfaces for vector ALU operands and results.
`timescale 1ns / 1ps
interface v3alu_in_if;
  import v3alu_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface v3alu_out_if;
  import v3alu_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/v3alu_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module v3alu_sqrt_pipe #(
  parameter int SideW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [v3alu_pkg::RadW-1:0]  rad_i,
  input  logic [SideW-1:0]            side_i,
  output logic                        valid_o,
  output logic [v3alu_pkg::DataW-1:0] root_o,
  output logic [SideW-1:0]            side_o
);
  import v3alu_pkg::*;

  localparam int RemW = DataW + 2;

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [DataW-1:0] root;
  } step_t;

  logic             vld_q  [SqrtSteps];
  step_t            st_q   [SqrtSteps];
  step_t            st_d   [SqrtSteps];
  logic [SideW-1:0] side_q [SqrtSteps];

  // one root bit per stage: bring down two radicand bits, trial subtract
  always_comb begin
    step_t           src;
    logic [RemW+1:0] remx;
    logic [RemW+1:0] trial;
    logic            ge;
    for (int s = 0; s < SqrtSteps; s++) begin
      if (s == 0) begin
        src.rad  = rad_i;
        src.rem  = '0;
        src.root = '0;
      end else begin
        src = st_q[s-1];
      end
      remx  = {src.rem, src.rad[RadW-1 -: 2]};
      trial = {2'b00, src.root, 2'b01};
      ge    = (remx >= trial);
      st_d[s].rad  = {src.rad[RadW-3:0], 2'b00};
      st_d[s].rem  = ge ? RemW'(remx - trial) : RemW'(remx);
      st_d[s].root = {src.root[DataW-2:0], ge};
    end
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SqrtSteps; s++) vld_q[s] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < SqrtSteps; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 0; s < SqrtSteps; s++) st_q[s] <= st_d[s];
      for (int s = 1; s < SqrtSteps; s++) side_q[s] <= side_q[s-1];
    end
  end

  assign valid_o = vld_q[SqrtSteps-1];
  assign root_o  = st_q[SqrtSteps-1].root;
  assign side_o  = side_q[SqrtSteps-1];

endmodule

[rtl/v3alu_div_pipe.sv]
// Three-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module v3alu_div_pipe #(
  parameter int FracBits = 16,
  parameter int SideW    = 1
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 en_i,
  input  logic                                                 valid_i,
  input  logic [v3alu_pkg::Lanes-1:0][v3alu_pkg::DataW-1:0]    nmag_i,
  input  logic [v3alu_pkg::Lanes-1:0][v3alu_pkg::DataW-1:0]    dmag_i,
  input  logic [v3alu_pkg::Lanes-1:0]                          neg_i,
  input  logic [SideW-1:0]                                     side_i,
  output logic                                                 valid_o,
  output logic [v3alu_pkg::Lanes-1:0][v3alu_pkg::DataW+FracBits-1:0] quot_o,
  output logic [v3alu_pkg::Lanes-1:0]                          neg_o,
  output logic [v3alu_pkg::Lanes-1:0]                          dz_o,
  output logic [SideW-1:0]                                     side_o
);
  import v3alu_pkg::*;

  localparam int NumW = DataW + FracBits;

  // the dividend register fills with quotient bits as it shifts out
  typedef struct packed {
    logic [NumW-1:0]  num;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] dmag;
    logic             neg;
  } lane_t;

  logic                  vld_q  [NumW];
  lane_t [Lanes-1:0]     st_q   [NumW];
  lane_t [Lanes-1:0]     st_d   [NumW];
  logic [SideW-1:0]      side_q [NumW];

  // shift in one dividend bit, subtract divisor when it fits
  always_comb begin
    lane_t          src;
    logic [DataW:0] remx;
    logic           ge;
    for (int s = 0; s < NumW; s++) begin
      for (int l = 0; l < Lanes; l++) begin
        if (s == 0) begin
          src.num  = {nmag_i[l], {FracBits{1'b0}}};
          src.rem  = '0;
          src.dmag = dmag_i[l];
          src.neg  = neg_i[l];
        end else begin
          src = st_q[s-1][l];
        end
        remx = {src.rem, src.num[NumW-1]};
        ge   = (remx >= {1'b0, src.dmag});
        st_d[s][l].num  = {src.num[NumW-2:0], ge};
        st_d[s][l].rem  = ge ? DataW'(remx - {1'b0, src.dmag}) : remx[DataW-1:0];
        st_d[s][l].dmag = src.dmag;
        st_d[s][l].neg  = src.neg;
      end
    end
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumW; s++) vld_q[s] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < NumW; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 0; s < NumW; s++) st_q[s] <= st_d[s];
      for (int s = 1; s < NumW; s++) side_q[s] <= side_q[s-1];
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      quot_o[l] = st_q[NumW-1][l].num;
      neg_o[l]  = st_q[NumW-1][l].neg;
      dz_o[l]   = (st_q[NumW-1][l].dmag == '0);
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign side_o  = side_q[NumW-1];

endmodule

[rtl/vector3_arithmetic_unit.sv]
// Top level of the three-component vector ALU.
`timescale 1ns / 1ps
// Fixed-point vector ALU: add, sub, element-wise mul/div, scale, divide by
// scalar, cross, dot, squared length, length and normalize on signed Q-format
// vectors with FRAC_BITS fraction bits. Every operation takes the same path:
// input register, six parallel 32x32 multipliers, a sum stage, a round and
// clip stage, a 32-stage square root and a (32 + FRAC_BITS)-stage divider,
// then the output register. A new transaction is taken every cycle unless a
// result is held at the output. A result that the sink does not take holds
// the whole pipe, so in_i.ready follows out_o.ready whenever the output
// register is full. Results that overflow saturate and set saturated; a zero
// divisor zeroes its component and sets div_by_zero.
module vector3_arithmetic_unit #(
  parameter int FRAC_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  v3alu_in_if.sink   in_i,
  v3alu_out_if.source out_o
);
  import v3alu_pkg::*;

  localparam int QuotW = DataW + FRAC_BITS;
  localparam logic signed [SumW-1:0] RoundHalf = SumW'(1) << (FRAC_BITS - 1);
  localparam logic [QuotW-1:0] QuotLim = QuotW'(ValMin);

  logic en;
  logic out_vld_q;

  // ---------------- stage A: input register
  logic     a_vld_q;
  in_item_t a_q;

  assign en       = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= in_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) a_q <= in_i.data;
  end

  // ---------------- stage B: multiplier operand select and products
  logic signed [DataW-1:0] op_l [6];
  logic signed [DataW-1:0] op_r [6];
  logic signed [ProdW-1:0] prod_d [6];
  logic signed [DataW:0]   as_d [Lanes];
  logic signed [DataW-1:0] den_d [Lanes];

  always_comb begin
    logic signed [DataW-1:0] av [Lanes];
    logic signed [DataW-1:0] bv [Lanes];
    av[0] = a_q.ax; av[1] = a_q.ay; av[2] = a_q.az;
    bv[0] = a_q.bx; bv[1] = a_q.by; bv[2] = a_q.bz;
    // cross product subtrahends always sit on multipliers three to five
    op_l[3] = a_q.az; op_r[3] = a_q.by;
    op_l[4] = a_q.ax; op_r[4] = a_q.bz;
    op_l[5] = a_q.ay; op_r[5] = a_q.bx;
    for (int l = 0; l < Lanes; l++) begin
      op_l[l]  = av[l];
      op_r[l]  = bv[l];
      as_d[l]  = (a_q.kind == KSub) ? av[l] - bv[l] : av[l] + bv[l];
      den_d[l] = (a_q.kind == KDivS) ? a_q.scalar_in : bv[l];
    end
    case (a_q.kind) inside
      KScale: begin
        for (int l = 0; l < Lanes; l++) op_r[l] = a_q.scalar_in;
      end
      KCross: begin
        op_l[0] = a_q.ay; op_r[0] = a_q.bz;
        op_l[1] = a_q.az; op_r[1] = a_q.bx;
        op_l[2] = a_q.ax; op_r[2] = a_q.by;
      end
      KSqLen, KLen, KNorm: begin
        for (int l = 0; l < Lanes; l++) op_r[l] = av[l];
      end
      default: begin
      end
    endcase
    for (int m = 0; m < 6; m++) prod_d[m] = op_l[m] * op_r[m];
  end

  logic                    b_vld_q;
  logic [3:0]              b_kind_q;
  logic signed [ProdW-1:0] b_prod_q [6];
  logic signed [DataW:0]   b_as_q [Lanes];
  logic [DataW-1:0]        b_num_q [Lanes];
  logic [DataW-1:0]        b_den_q [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (en) b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_kind_q   <= a_q.kind;
      b_num_q[0] <= a_q.ax;
      b_num_q[1] <= a_q.ay;
      b_num_q[2] <= a_q.az;
      for (int m = 0; m < 6; m++) b_prod_q[m] <= prod_d[m];
      for (int l = 0; l < Lanes; l++) begin
        b_as_q[l]  <= as_d[l];
        b_den_q[l] <= den_d[l];
      end
    end
  end

  // ---------------- stage C: exact product sums, clip add/sub
  logic signed [SumW-1:0] sum_d [Lanes];
  sat_t                   as_sat_d [Lanes];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      sum_d[l]    = SumW'(b_prod_q[l]);
      as_sat_d[l] = sat32(SumW'(b_as_q[l]));
    end
    case (b_kind_q) inside
      KCross: begin
        for (int l = 0; l < Lanes; l++) begin
          sum_d[l] = SumW'(b_prod_q[l]) - SumW'(b_prod_q[l+3]);
        end
      end
      KDot, KSqLen, KLen, KNorm: begin
        sum_d[0] = SumW'(b_prod_q[0]) + SumW'(b_prod_q[1]) + SumW'(b_prod_q[2]);
      end
      default: begin
      end
    endcase
  end

  logic                   c_vld_q;
  logic [3:0]             c_kind_q;
  logic signed [SumW-1:0] c_sum_q [Lanes];
  sat_t                   c_as_q [Lanes];
  logic [DataW-1:0]       c_num_q [Lanes];
  logic [DataW-1:0]       c_den_q [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else if (en) c_vld_q <= b_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_kind_q <= b_kind_q;
      for (int l = 0; l < Lanes; l++) begin
        c_sum_q[l] <= sum_d[l];
        c_as_q[l]  <= as_sat_d[l];
        c_num_q[l] <= b_num_q[l];
        c_den_q[l] <= b_den_q[l];
      end
    end
  end

  // ---------------- stage D: round half up, clip, pick early result
  sat_t     rnd_d [Lanes];
  sq_side_t d_side_d;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      rnd_d[l] = sat32((c_sum_q[l] + RoundHalf) >>> FRAC_BITS);
      d_side_d.num[l] = c_num_q[l];
      d_side_d.den[l] = c_den_q[l];
    end
    d_side_d.early      = '0;
    d_side_d.early.kind = c_kind_q;
    case (c_kind_q) inside
      KAdd, KSub: begin
        d_side_d.early.rx  = c_as_q[0].val;
        d_side_d.early.ry  = c_as_q[1].val;
        d_side_d.early.rz  = c_as_q[2].val;
        d_side_d.early.sat = c_as_q[0].sat | c_as_q[1].sat | c_as_q[2].sat;
      end
      KMul, KScale, KCross: begin
        d_side_d.early.rx  = rnd_d[0].val;
        d_side_d.early.ry  = rnd_d[1].val;
        d_side_d.early.rz  = rnd_d[2].val;
        d_side_d.early.sat = rnd_d[0].sat | rnd_d[1].sat | rnd_d[2].sat;
      end
      KDot, KSqLen: begin
        d_side_d.early.so  = rnd_d[0].val;
        d_side_d.early.sat = rnd_d[0].sat;
      end
      default: begin
      end
    endcase
  end

  logic            d_vld_q;
  sq_side_t        d_side_q;
  logic [RadW-1:0] d_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else if (en) d_vld_q <= c_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_side_q <= d_side_d;
      d_rad_q  <= c_sum_q[0][RadW-1:0];
    end
  end

  // ---------------- square root of the squared length
  logic             sq_vld;
  logic [DataW-1:0] sq_root;
  sq_side_t         sq_side;

  v3alu_sqrt_pipe #(
    .SideW ($bits(sq_side_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld_q),
    .rad_i   (d_rad_q),
    .side_i  (d_side_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // take magnitudes for the divider; normalize divides by the length
  logic [Lanes-1:0][DataW-1:0] dv_nmag;
  logic [Lanes-1:0][DataW-1:0] dv_dmag;
  logic [Lanes-1:0]            dv_negi;
  early_t                      dv_early;

  always_comb begin
    logic [DataW-1:0] nv;
    logic [DataW-1:0] dv;
    dv_early = sq_side.early;
    if (sq_side.early.kind == KLen) begin
      dv_early.so  = sq_root[DataW-1] ? ValMax : sq_root;
      dv_early.sat = sq_root[DataW-1];
    end
    for (int l = 0; l < Lanes; l++) begin
      nv = sq_side.num[l];
      dv = sq_side.den[l];
      dv_nmag[l] = nv[DataW-1] ? DataW'(-nv) : nv;
      if (sq_side.early.kind == KNorm) begin
        dv_dmag[l] = sq_root;
        dv_negi[l] = nv[DataW-1];
      end else begin
        dv_dmag[l] = dv[DataW-1] ? DataW'(-dv) : dv;
        dv_negi[l] = nv[DataW-1] ^ dv[DataW-1];
      end
    end
  end

  // ---------------- quotients
  logic                        dv_vld;
  logic [Lanes-1:0][QuotW-1:0] dv_quot;
  logic [Lanes-1:0]            dv_neg;
  logic [Lanes-1:0]            dv_dz;
  early_t                      dv_side;

  v3alu_div_pipe #(
    .FracBits (FRAC_BITS),
    .SideW    ($bits(early_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .nmag_i  (dv_nmag),
    .dmag_i  (dv_dmag),
    .neg_i   (dv_negi),
    .side_i  (dv_early),
    .valid_o (dv_vld),
    .quot_o  (dv_quot),
    .neg_o   (dv_neg),
    .dz_o    (dv_dz),
    .side_o  (dv_side)
  );

  // ---------------- output: sign and clip quotients, merge early results
  out_item_t out_d;
  out_item_t out_q;
  logic [3:0] out_kind_q;

  always_comb begin
    logic [Lanes-1:0][DataW-1:0] qv;
    logic [Lanes-1:0]            qs;
    for (int l = 0; l < Lanes; l++) begin
      qs[l] = 1'b0;
      if (dv_dz[l]) begin
        qv[l] = '0;
      end else if (dv_neg[l]) begin
        if (dv_quot[l] > QuotLim) begin
          qv[l] = ValMin;
          qs[l] = 1'b1;
        end else begin
          qv[l] = -dv_quot[l][DataW-1:0];
        end
      end else if (dv_quot[l] >= QuotLim) begin
        qv[l] = ValMax;
        qs[l] = 1'b1;
      end else begin
        qv[l] = dv_quot[l][DataW-1:0];
      end
    end
    case (dv_side.kind) inside
      KDiv, KDivS, KNorm: begin
        out_d.rx          = qv[0];
        out_d.ry          = qv[1];
        out_d.rz          = qv[2];
        out_d.scalar_out  = '0;
        out_d.div_by_zero = |dv_dz;
        out_d.saturated   = |qs;
      end
      default: begin
        out_d.rx          = dv_side.rx;
        out_d.ry          = dv_side.ry;
        out_d.rz          = dv_side.rz;
        out_d.scalar_out  = dv_side.so;
        out_d.div_by_zero = 1'b0;
        out_d.saturated   = dv_side.sat;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= dv_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q      <= out_d;
      out_kind_q <= dv_side.kind;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // ---------------- checks
  a_dz_only_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.div_by_zero) |->
      (out_kind_q == KDiv || out_kind_q == KDivS || out_kind_q == KNorm))
    else $error("div_by_zero raised on a kind without a divide");

  a_scalar_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_kind_q == KDot || out_kind_q == KSqLen || out_kind_q == KLen)) |->
      (out_q.rx == '0 && out_q.ry == '0 && out_q.rz == '0))
    else $error("scalar operation left a nonzero vector");

  a_unused_kind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q > KNorm) |-> (out_q == '0))
    else $error("unused kind gave a nonzero result");

endmodule
